// ----- rtl/core/hid_report_reassembler_unit_assert.svh -----
// Assertion macros used by the checker file of this block.
// Each macro takes a label, an enabling condition and a consequence.
`ifndef HID_REPORT_REASSEMBLER_UNIT_ASSERT_SVH
`define HID_REPORT_REASSEMBLER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define HRR_ASSERT_SAME(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("hrr check failed");

// The consequence must hold in the cycle after the condition.
`define HRR_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("hrr check failed");

`endif

// ----- rtl/core/hrr_pkg.sv -----
package hrr_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 256;

	localparam int unsigned IN_DATA_W = 264;
	localparam int unsigned OUT_DATA_W = 256;
	localparam int unsigned OUT_USER_W = 2;

	localparam int unsigned PAYLOAD_BYTES = 25;
	localparam int unsigned HELLO_LEN = 5;
	localparam int unsigned OK_LEN = 18;
	localparam int unsigned ERR_LEN = 15;
	localparam int unsigned REPLY_BYTES = 32;
	localparam int unsigned REPLY_SEQ_LSB = 32;

	localparam logic [7:0] REPORT_LEN = 8'd32;
	localparam logic [7:0] HDR_MAGIC0 = 8'h4C;
	localparam logic [7:0] HDR_MAGIC1 = 8'h51;
	localparam logic [7:0] HDR_VERSION = 8'h01;
	localparam logic [7:0] FL_REPLY = 8'h07;

	localparam int unsigned FL_START_BIT = 0;
	localparam int unsigned FL_END_BIT = 1;
	localparam int unsigned FL_RESP_BIT = 2;

	localparam logic [7:0] HELLO_TEXT [HELLO_LEN] = '{8'h48, 8'h45, 8'h4C, 8'h4C, 8'h4F};

	localparam logic [7:0] OK_TEXT [OK_LEN] = '{
		8'h4C, 8'h55, 8'h4D, 8'h49, 8'h50, 8'h41, 8'h44, 8'h7C, 8'h33,
		8'h7C, 8'h46, 8'h57, 8'h3D, 8'h30, 8'h2E, 8'h32, 8'h2E, 8'h31
	};

	localparam logic [7:0] ERR_TEXT [ERR_LEN] = '{
		8'h45, 8'h52, 8'h52, 8'h7C, 8'h55, 8'h4E, 8'h53, 8'h55,
		8'h50, 8'h50, 8'h4F, 8'h52, 8'h54, 8'h45, 8'h44
	};

	typedef struct packed {
		logic [7:0]  payload_d;
		logic [63:0] payload_c;
		logic [63:0] payload_b;
		logic [63:0] payload_a;
		logic [7:0]  count;
		logic [7:0]  fragment;
		logic [7:0]  sequence_req;
		logic [7:0]  flags;
		logic [7:0]  version;
		logic [7:0]  magic_1;
		logic [7:0]  magic_0;
		logic [7:0]  length;
	} in_beat_t;

	typedef struct packed {
		logic reply_valid;
		logic claimed;
	} out_user_t;

	function automatic logic [7:0] reply_byte(input logic ok, input int unsigned pos);
		logic [7:0] val;
		int unsigned txt_len;
		txt_len = ok ? OK_LEN : ERR_LEN;
		val = 8'h00;
		case (pos)
			0: val = HDR_MAGIC0;
			1: val = HDR_MAGIC1;
			2: val = HDR_VERSION;
			3: val = FL_REPLY;
			6: val = 8'(txt_len);
			default: begin
				if (pos >= 7 && pos < 7 + txt_len) begin
					if (ok) begin
						val = OK_TEXT[pos - 7];
					end else begin
						val = ERR_TEXT[pos - 7];
					end
				end
			end
		endcase
		return val;
	endfunction

	function automatic logic [OUT_DATA_W-1:0] reply_image(input logic ok);
		logic [OUT_DATA_W-1:0] img;
		img = '0;
		for (int unsigned i = 0; i < REPLY_BYTES; i++) begin
			img[8*i +: 8] = reply_byte(ok, i);
		end
		return img;
	endfunction

	localparam logic [OUT_DATA_W-1:0] REPLY_OK_IMAGE = reply_image(1'b1);
	localparam logic [OUT_DATA_W-1:0] REPLY_ERR_IMAGE = reply_image(1'b0);

endpackage

// ----- rtl/core/hid_report_reassembler_unit.sv -----
// Channel   Direction  tdata (low bit up)                              tuser (low bit up)
// s_axis    in         length, magic_0, magic_1, version, flags,       none
//                      sequence_req, fragment, count, payload_a..d
// m_axis    out        reply_word_0, reply_word_1, reply_word_2,       claimed, reply_valid
//                      reply_word_3
//
// Every input beat yields exactly one output beat, via the input register and then the output register.
// One beat is taken per cycle while the output is not stalled; the limit is the single state update between the
// input register and the output register.
// The asynchronous reset clears the message state and both pipeline valids.
// A stalled output holds its beat while the input register still takes one more beat.
module hid_report_reassembler_unit
	import hrr_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// length, magic_0, magic_1, version, flags, sequence_req, fragment, count,
	// payload_a, payload_b, payload_c, payload_d
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// reply_word_0, reply_word_1, reply_word_2, reply_word_3
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// claimed, reply_valid
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int unsigned SUM_W = ((LEN_W > 8) ? LEN_W : 8) + 1;

	in_beat_t              beat_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;
	out_user_t             user_s2;

	logic                  assembling_q;
	logic [7:0]            exp_seq_q;
	logic [7:0]            exp_frag_q;
	logic [LEN_W-1:0]      msg_len_q;
	logic [2:0]            match_idx_q;
	logic                  mismatch_q;
	logic                  term_q;

	logic                  advance;
	logic [8*PAYLOAD_BYTES-1:0] pay;
	logic                  hdr_ok;
	logic                  proc;
	logic                  start;
	logic                  eff_asm;
	logic [7:0]            eff_seq;
	logic [7:0]            eff_frag;
	logic [LEN_W-1:0]      eff_len;
	logic [2:0]            eff_mi;
	logic                  eff_mis;
	logic                  eff_term;
	logic [SUM_W-1:0]      len_sum;
	logic                  take;
	logic                  finish;
	logic [PAYLOAD_BYTES-1:0] in_rng;
	logic [PAYLOAD_BYTES-1:0] zr;
	logic [PAYLOAD_BYTES-1:0] hit;
	logic [PAYLOAD_BYTES-1:0] mis;
	logic [3:0]            pos_sum;
	logic [2:0]            hit_cnt;
	logic                  new_term;
	logic                  new_mis;
	logic [2:0]            new_mi;
	logic                  reply_ok;
	logic [OUT_DATA_W-1:0] reply_word;
	out_user_t             user_d;

	assign advance = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = data_s2;
	assign m_axis_tuser = user_s2;

	always_comb begin
		pay = {beat_s1.payload_d, beat_s1.payload_c, beat_s1.payload_b, beat_s1.payload_a};
		hdr_ok = (beat_s1.length == REPORT_LEN) && (beat_s1.magic_0 == HDR_MAGIC0) &&
			(beat_s1.magic_1 == HDR_MAGIC1) && (beat_s1.version == HDR_VERSION);
		proc = hdr_ok && !beat_s1.flags[FL_RESP_BIT] &&
			(beat_s1.count <= 8'(PAYLOAD_BYTES));
		start = beat_s1.flags[FL_START_BIT];

		eff_asm = start ? 1'b1 : assembling_q;
		eff_seq = start ? beat_s1.sequence_req : exp_seq_q;
		eff_frag = start ? 8'd0 : exp_frag_q;
		eff_len = start ? '0 : msg_len_q;
		eff_mi = start ? 3'd0 : match_idx_q;
		eff_mis = start ? 1'b0 : mismatch_q;
		eff_term = start ? 1'b0 : term_q;

		len_sum = SUM_W'(eff_len) + SUM_W'(beat_s1.count);
		take = eff_asm && (beat_s1.sequence_req == eff_seq) &&
			(beat_s1.fragment == eff_frag) && (len_sum <= SUM_W'(MAX_MESSAGE_BYTES));
		finish = proc && take && beat_s1.flags[FL_END_BIT];

		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			in_rng[i] = beat_s1.count > 8'(i);
			zr[i] = in_rng[i] && (pay[8*i +: 8] == 8'h00);
		end

		pos_sum = '0;
		hit_cnt = '0;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			hit[i] = !eff_term && in_rng[i] && (pay[8*i +: 8] != 8'h00) &&
				((zr & ((PAYLOAD_BYTES'(1) << i) - PAYLOAD_BYTES'(1))) == '0);
			if (i < HELLO_LEN) begin
				pos_sum = 4'(eff_mi) + 4'(i);
				mis[i] = hit[i] && ((pos_sum >= 4'(HELLO_LEN)) ||
					(pay[8*i +: 8] != HELLO_TEXT[pos_sum[2:0]]));
				hit_cnt = hit_cnt + 3'(hit[i]);
			end else begin
				mis[i] = hit[i];
			end
		end

		new_term = eff_term || (|zr);
		new_mis = eff_mis || (|mis);
		new_mi = new_mis ? eff_mi : 3'(eff_mi + hit_cnt);
		reply_ok = !new_mis && (new_mi == 3'(HELLO_LEN));

		reply_word = reply_ok ? REPLY_OK_IMAGE : REPLY_ERR_IMAGE;
		reply_word[REPLY_SEQ_LSB +: 8] = beat_s1.sequence_req;
		if (!finish) begin
			reply_word = '0;
		end
		user_d.claimed = hdr_ok;
		user_d.reply_valid = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			assembling_q <= 1'b0;
			exp_seq_q <= 8'd0;
			exp_frag_q <= 8'd0;
			msg_len_q <= '0;
			match_idx_q <= 3'd0;
			mismatch_q <= 1'b0;
			term_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1 && proc) begin
				assembling_q <= take && !beat_s1.flags[FL_END_BIT];
				exp_seq_q <= eff_seq;
				if (take) begin
					exp_frag_q <= 8'(eff_frag + 8'd1);
					msg_len_q <= LEN_W'(len_sum);
					match_idx_q <= new_mi;
					mismatch_q <= new_mis;
					term_q <= new_term;
				end else begin
					exp_frag_q <= eff_frag;
					msg_len_q <= eff_len;
					match_idx_q <= eff_mi;
					mismatch_q <= eff_mis;
					term_q <= eff_term;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			beat_s1 <= in_beat_t'(s_axis_tdata);
		end
		if (advance && valid_s1) begin
			data_s2 <= reply_word;
			user_s2 <= user_d;
		end
	end

endmodule

// ----- rtl/core/hrr_checker.sv -----
`include "hid_report_reassembler_unit_assert.svh"

module hrr_checker
	import hrr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	out_user_t user;
	logic      out_held;
	logic      reply_hdr_ok;
	logic [OUT_DATA_W+OUT_USER_W-1:0] out_beat;

	assign user = m_axis_tuser;
	assign out_held = m_axis_tvalid && !m_axis_tready;
	assign out_beat = {m_axis_tuser, m_axis_tdata};
	assign reply_hdr_ok = user.claimed && (m_axis_tdata[31:0] == REPLY_OK_IMAGE[31:0]);

	// A held output beat must not change.
	`HRR_ASSERT_NEXT(a_out_hold, out_held, m_axis_tvalid && $stable(out_beat))

	// With the output stage empty, the input side is never stalled.
	`HRR_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

	// Only a claimed report can complete a message, and replies carry a fixed header.
	`HRR_ASSERT_SAME(a_reply_claimed, m_axis_tvalid && user.reply_valid, reply_hdr_ok)

	// Without a reply the reply words are all zero.
	`HRR_ASSERT_SAME(a_no_reply_zero, m_axis_tvalid && !user.reply_valid, m_axis_tdata == '0)

endmodule

bind hid_report_reassembler_unit hrr_checker u_hrr_checker (.*);
